### src/lcgrr_pkg.sv
// Package for the ranged linear congruential generator.
// Holds field widths, operation and register codes, reset constants and the
// command/status structs shared by the controller, datapath and top level.
package lcgrr_pkg;

    localparam int SeedW  = 18;
    localparam int MultW  = 13;
    localparam int IncW   = 16;
    localparam int ValW   = 31;
    localparam int FuncW  = 2;
    localparam int WideW  = 32;
    localparam int CntW   = 5;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 18;

    // Operation codes carried by the func field.
    localparam logic [FuncW-1:0] FUNC_RESEED  = 2'd0;
    localparam logic [FuncW-1:0] FUNC_RAW     = 2'd1;
    localparam logic [FuncW-1:0] FUNC_BOUNDED = 2'd2;
    localparam logic [FuncW-1:0] FUNC_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_INCREMENT  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MODULUS    = 2'd2;

    // Reset values.
    localparam logic [MultW-1:0] MULT_RESET = 13'd8121;
    localparam logic [IncW-1:0]  INC_RESET  = 16'd28411;
    localparam logic [SeedW-1:0] MOD_RESET  = 18'd134456;
    localparam logic [SeedW-1:0] SEED_RESET = 18'd1234;

    // Iteration counts of the shared restoring divider, minus one.
    localparam logic [CntW-1:0] MOD_STEPS_M1 = CntW'(WideW - 1);
    localparam logic [CntW-1:0] RNG_STEPS_M1 = CntW'(SeedW - 1);

    // Result selection codes.
    localparam logic [1:0] OUT_SEED = 2'd0;
    localparam logic [1:0] OUT_LOW  = 2'd1;
    localparam logic [1:0] OUT_SUM  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       seed_wr_in;
        logic       mul;
        logic       mod_start;
        logic       rng_start;
        logic       div_step;
        logic       seed_wr_prod;
        logic       seed_wr_rem;
        logic       publish;
        logic [1:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic             mod_zero;
        logic             range_err;
        logic             div_last;
    } status_t;

endpackage

### src/lcgrr_ctrl.sv
// Controller state machine for the ranged linear congruential generator.
// Sequences the multiply, the two divider passes and the result handoff.
// Depends on lcgrr_pkg for command/status types and codes.
module lcgrr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  lcgrr_pkg::status_t sts,
    output lcgrr_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_MODLD  = 3'd2;
    localparam logic [2:0] ST_MODDIV = 3'd3;
    localparam logic [2:0] ST_SEEDWR = 3'd4;
    localparam logic [2:0] ST_POST   = 3'd5;
    localparam logic [2:0] ST_RNGDIV = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = lcgrr_pkg::OUT_SEED;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.func)
                    lcgrr_pkg::FUNC_RESEED:
                    begin
                        cmd.seed_wr_in = 1'b1;
                        state_next     = ST_FIN;
                    end
                    lcgrr_pkg::FUNC_RAW, lcgrr_pkg::FUNC_BOUNDED:
                    begin
                        cmd.mul    = 1'b1;
                        state_next = ST_MODLD;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MODLD:
            begin
                if (sts.mod_zero)
                begin
                    cmd.seed_wr_prod = 1'b1;
                    state_next       = ST_POST;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_MODDIV;
                end
            end
            ST_MODDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SEEDWR;
                end
            end
            ST_SEEDWR:
            begin
                cmd.seed_wr_rem = 1'b1;
                state_next      = ST_POST;
            end
            ST_POST:
            begin
                if ((sts.func == lcgrr_pkg::FUNC_BOUNDED) && !sts.range_err)
                begin
                    cmd.rng_start = 1'b1;
                    state_next    = ST_RNGDIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RNGDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.func == lcgrr_pkg::FUNC_BOUNDED)
                begin
                    cmd.out_sel = sts.range_err ? lcgrr_pkg::OUT_LOW : lcgrr_pkg::OUT_SUM;
                end
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/lcgrr_dpath.sv
// Datapath for the ranged linear congruential generator: configuration
// registers, seed, multiply-add, shared restoring divider and result register.
// Depends on lcgrr_pkg for widths, codes and command/status types.
module lcgrr_dpath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr,
    input  logic [lcgrr_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [lcgrr_pkg::CfgDataW-1:0]        cfg_data,
    input  logic [lcgrr_pkg::FuncW-1:0]           func,
    input  logic [lcgrr_pkg::SeedW-1:0]           seed_value,
    input  logic signed [lcgrr_pkg::ValW-1:0]     range_low,
    input  logic signed [lcgrr_pkg::ValW-1:0]     range_high,
    input  lcgrr_pkg::cmd_t                       cmd,
    output lcgrr_pkg::status_t                    sts,
    output logic signed [lcgrr_pkg::ValW-1:0]     value,
    output logic                                  range_error
);

    logic [lcgrr_pkg::MultW-1:0]        mult_reg;
    logic [lcgrr_pkg::IncW-1:0]         inc_reg;
    logic [lcgrr_pkg::SeedW-1:0]        mod_reg;
    logic [lcgrr_pkg::SeedW-1:0]        seed_reg;
    logic [lcgrr_pkg::FuncW-1:0]        func_reg;
    logic [lcgrr_pkg::SeedW-1:0]        seed_in_reg;
    logic signed [lcgrr_pkg::ValW-1:0]  low_reg;
    logic signed [lcgrr_pkg::ValW-1:0]  high_reg;
    logic [lcgrr_pkg::WideW-1:0]        prod_reg;
    logic [lcgrr_pkg::WideW-1:0]        rem_reg;
    logic [lcgrr_pkg::WideW-1:0]        dvd_reg;
    logic [lcgrr_pkg::WideW-1:0]        dvs_reg;
    logic [lcgrr_pkg::CntW-1:0]         cnt_reg;
    logic signed [lcgrr_pkg::ValW-1:0]  value_reg;
    logic                               err_reg;

    logic [lcgrr_pkg::ValW-1:0]         mprod;
    logic [lcgrr_pkg::WideW-1:0]        prod_next;
    logic signed [lcgrr_pkg::WideW-1:0] diff;
    logic                               err;
    logic [lcgrr_pkg::WideW:0]          trial;
    logic [lcgrr_pkg::WideW:0]          trial_sub;
    logic [lcgrr_pkg::WideW-1:0]        rem_next;
    logic signed [lcgrr_pkg::ValW-1:0]  value_next;

    assign mprod     = lcgrr_pkg::ValW'(mult_reg) * lcgrr_pkg::ValW'(seed_reg);
    assign prod_next = lcgrr_pkg::WideW'(mprod) + lcgrr_pkg::WideW'(inc_reg);

    // Exact range width; a zero or negative width is an error.
    assign diff = {high_reg[lcgrr_pkg::ValW-1], high_reg}
                - {low_reg[lcgrr_pkg::ValW-1], low_reg};
    assign err  = diff[lcgrr_pkg::WideW-1] || (diff == '0);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial     = {rem_reg, dvd_reg[lcgrr_pkg::WideW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign rem_next  = trial_sub[lcgrr_pkg::WideW] ? trial[lcgrr_pkg::WideW-1:0]
                                                   : trial_sub[lcgrr_pkg::WideW-1:0];

    always_comb
    begin
        case (cmd.out_sel)
            lcgrr_pkg::OUT_LOW: value_next = low_reg;
            lcgrr_pkg::OUT_SUM: value_next = low_reg + $signed(rem_reg[lcgrr_pkg::ValW-1:0]);
            default:            value_next = $signed(lcgrr_pkg::ValW'(seed_reg));
        endcase
    end

    assign sts.func      = func_reg;
    assign sts.mod_zero  = (mod_reg == '0);
    assign sts.range_err = err;
    assign sts.div_last  = (cnt_reg == '0);

    assign value       = value_reg;
    assign range_error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= lcgrr_pkg::MULT_RESET;
            inc_reg  <= lcgrr_pkg::INC_RESET;
            mod_reg  <= lcgrr_pkg::MOD_RESET;
            seed_reg <= lcgrr_pkg::SEED_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    lcgrr_pkg::REG_MULTIPLIER: mult_reg <= cfg_data[lcgrr_pkg::MultW-1:0];
                    lcgrr_pkg::REG_INCREMENT:  inc_reg  <= cfg_data[lcgrr_pkg::IncW-1:0];
                    lcgrr_pkg::REG_MODULUS:    mod_reg  <= cfg_data[lcgrr_pkg::SeedW-1:0];
                    default:                   ;
                endcase
            end
            if (cmd.seed_wr_in)
            begin
                seed_reg <= seed_in_reg;
            end
            else if (cmd.seed_wr_prod)
            begin
                seed_reg <= prod_reg[lcgrr_pkg::SeedW-1:0];
            end
            else if (cmd.seed_wr_rem)
            begin
                seed_reg <= rem_reg[lcgrr_pkg::SeedW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            seed_in_reg <= seed_value;
            low_reg     <= range_low;
            high_reg    <= range_high;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mod_start)
        begin
            rem_reg <= '0;
            dvd_reg <= prod_reg;
            dvs_reg <= lcgrr_pkg::WideW'(mod_reg);
            cnt_reg <= lcgrr_pkg::MOD_STEPS_M1;
        end
        else if (cmd.rng_start)
        begin
            rem_reg <= '0;
            dvd_reg <= {seed_reg, {(lcgrr_pkg::WideW - lcgrr_pkg::SeedW){1'b0}}};
            dvs_reg <= diff;
            cnt_reg <= lcgrr_pkg::RNG_STEPS_M1;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[lcgrr_pkg::WideW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.publish)
        begin
            value_reg <= value_next;
            err_reg   <= (cmd.out_sel == lcgrr_pkg::OUT_LOW);
        end
    end

endmodule

### src/lcg_random_with_range.sv
// Top level of the ranged linear congruential generator.
// Instantiates lcgrr_ctrl and lcgrr_dpath; depends on lcgrr_pkg.
//
// The input channel (in_valid / in_stall) carries one request: func selects reseed,
// raw draw or bounded draw; seed_value, range_low and range_high are its operands.
// Each request yields exactly one result on the output channel (out_valid /
// out_stall): value is the echoed seed, the raw draw or the bounded result, and
// range_error flags an empty or inverted range on a bounded draw.
// The single shared restoring divider retires one quotient bit per cycle: 32 steps
// to reduce the 32-bit product by the modulus, then 18 steps to reduce the new
// seed by the range width. A reseed or an unused code skips the divider, a raw draw
// makes the first pass only and a bounded draw makes both; a bounded draw skips the
// second pass when the range is empty, and a draw skips the first when the modulus
// is zero. One request is in work at a time and in_stall is high while busy, so the
// next request is taken in the cycle after the result is loaded. A waiting result
// holds in the output register while the receiver stalls; the next result then
// waits in the controller until the register frees. Configuration writes
// (cfg_ready is always high) must be made only while idle; the block itself does
// not enforce this. Reset clears the controller, restores register defaults and
// loads seed 1234.
module lcg_random_with_range
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcgrr_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [lcgrr_pkg::CfgDataW-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lcgrr_pkg::FuncW-1:0]          func,
    input  logic [lcgrr_pkg::SeedW-1:0]          seed_value,
    input  logic signed [lcgrr_pkg::ValW-1:0]    range_low,
    input  logic signed [lcgrr_pkg::ValW-1:0]    range_high,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lcgrr_pkg::ValW-1:0]    value,
    output logic                                 range_error
);

    lcgrr_pkg::cmd_t    cmd;
    lcgrr_pkg::status_t sts;

    // Register writes are always taken; software must keep them to idle time, as the block does not.
    assign cfg_ready = 1'b1;

    lcgrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lcgrr_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .seed_value  (seed_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .cmd         (cmd),
        .sts         (sts),
        .value       (value),
        .range_error (range_error)
    );

endmodule
